// ----- sv/tmiw_pkg.sv -----
// Package with the constants, types and arithmetic helpers of the triclinic minimum-image unit.
`default_nettype none

package tmiw_pkg;

    // Number of add or subtract steps allowed in each direction of one fold.
    localparam int MAX_WRAPS = 4;

    // Three folds (z with c, y with b, x with a), two directions each.
    localparam int NUM_FOLDS = 3;
    localparam int NUM_STEPS = 2 * NUM_FOLDS * MAX_WRAPS;

    // Configuration register indexes.
    localparam logic [2:0] REG_CELL_A_X = 3'd0;
    localparam logic [2:0] REG_CELL_B_X = 3'd1;
    localparam logic [2:0] REG_CELL_B_Y = 3'd2;
    localparam logic [2:0] REG_CELL_C_X = 3'd3;
    localparam logic [2:0] REG_CELL_C_Y = 3'd4;
    localparam logic [2:0] REG_CELL_C_Z = 3'd5;

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    typedef logic [2:0] reg_idx_t;

    // Result of a saturating add: the clipped value and an overflow mark.
    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    // Signed addend, negated when subtracting; 33 bits hold the negated minimum.
    function automatic logic signed [32:0] addend(input logic signed [32:0] v,
                                                 input logic sub);
        logic signed [32:0] r;
        begin
            r = sub ? -v : v;
            return r;
        end
    endfunction

    // Add a 33-bit addend to a 32-bit value and clip to the signed 32-bit range.
    function automatic sat_t sat_add(input logic signed [31:0] a,
                                     input logic signed [32:0] b);
        logic signed [33:0] s;
        sat_t               r;
        begin
            s = {{2{a[31]}}, a} + {b[32], b};
            if (s > SAT_MAX)
            begin
                r.ovf = 1'b1;
                r.val = 32'sh7FFF_FFFF;
            end
            else if (s < SAT_MIN)
            begin
                r.ovf = 1'b1;
                r.val = 32'sh8000_0000;
            end
            else
            begin
                r.ovf = 1'b0;
                r.val = s[31:0];
            end
            return r;
        end
    endfunction

    // True when 2*k lies below -len.
    function automatic logic below_cell(input logic signed [31:0] k, input logic [30:0] len);
        logic signed [33:0] twok;
        logic signed [33:0] l;
        begin
            twok = {k[31], k, 1'b0};
            l    = {3'b000, len};
            return (twok < -l);
        end
    endfunction

    // True when 2*k lies above len.
    function automatic logic above_cell(input logic signed [31:0] k, input logic [30:0] len);
        logic signed [33:0] twok;
        logic signed [33:0] l;
        begin
            twok = {k[31], k, 1'b0};
            l    = {3'b000, len};
            return (twok > l);
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/triclinic_minimum_image_wrap_unit.sv -----
// Top level of the triclinic minimum-image fold: configuration registers and the fold pipeline.
// Path from start to done: the input capture register, one register per fold step, then the output register.
// Throughput: one transaction per cycle; every fold step is one pipeline stage.
// busy stays low, since the pipeline always advances and the receiver cannot stall.
// Reset clears the valid bits and loads the cell registers with their reset values.
`default_nettype none

module triclinic_minimum_image_wrap_unit
(
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    // Configuration write port
    input  wire  logic                cfg_write,
    input  wire  tmiw_pkg::reg_idx_t  cfg_index,
    input  wire  logic [31:0]         cfg_data,
    // Command side
    input  wire  logic                start,
    output logic                      busy,
    input  wire  logic signed [31:0]  disp_x,
    input  wire  logic signed [31:0]  disp_y,
    input  wire  logic signed [31:0]  disp_z,
    // Result side
    output logic                      done,
    output logic signed [31:0]        wrapped_x,
    output logic signed [31:0]        wrapped_y,
    output logic signed [31:0]        wrapped_z,
    output logic                      not_reduced
);
    import tmiw_pkg::*;

    logic [30:0]        cell_a_x_reg;
    logic signed [31:0] cell_b_x_reg;
    logic [30:0]        cell_b_y_reg;
    logic signed [31:0] cell_c_x_reg;
    logic signed [31:0] cell_c_y_reg;
    logic [30:0]        cell_c_z_reg;

    // Pipeline registers; entry 0 captures the transaction, entry s holds step s.
    logic               valid_reg [0:NUM_STEPS];
    logic signed [31:0] x_reg     [0:NUM_STEPS];
    logic signed [31:0] y_reg     [0:NUM_STEPS];
    logic signed [31:0] z_reg     [0:NUM_STEPS];
    logic               flag_reg  [0:NUM_STEPS];

    logic               done_reg;
    logic signed [31:0] wx_reg;
    logic signed [31:0] wy_reg;
    logic signed [31:0] wz_reg;
    logic               nr_reg;
    logic               nr_next;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_a_x_reg <= 31'h7FFF_FFFF;
            cell_b_x_reg <= 32'sd0;
            cell_b_y_reg <= 31'h7FFF_FFFF;
            cell_c_x_reg <= 32'sd0;
            cell_c_y_reg <= 32'sd0;
            cell_c_z_reg <= 31'h7FFF_FFFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CELL_A_X: cell_a_x_reg <= cfg_data[30:0];
                REG_CELL_B_X: cell_b_x_reg <= cfg_data;
                REG_CELL_B_Y: cell_b_y_reg <= cfg_data[30:0];
                REG_CELL_C_X: cell_c_x_reg <= cfg_data;
                REG_CELL_C_Y: cell_c_y_reg <= cfg_data;
                REG_CELL_C_Z: cell_c_z_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy = 1'b0;

    // Input capture stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= disp_x;
        y_reg[0]    <= disp_y;
        z_reg[0]    <= disp_z;
        flag_reg[0] <= 1'b0;
    end

    // One conditional add or subtract of a cell vector per stage.
    for (genvar g = 1; g <= NUM_STEPS; g++)
    begin : g_step
        localparam int  F     = (g - 1) / (2 * MAX_WRAPS);
        localparam bit  SUB   = (((g - 1) / MAX_WRAPS) % 2) == 1;
        localparam bit  FIRST = ((g - 1) % (2 * MAX_WRAPS)) == 0;

        logic signed [31:0] k_in;
        logic signed [31:0] p_in;
        logic signed [31:0] q_in;
        logic [30:0]        len;
        logic signed [31:0] dp;
        logic signed [31:0] dq;
        logic signed [31:0] prev_k;
        logic [30:0]        prev_len;
        logic               move;
        logic               prev_bad;
        sat_t               k_s;
        sat_t               p_s;
        sat_t               q_s;
        logic signed [31:0] x_next;
        logic signed [31:0] y_next;
        logic signed [31:0] z_next;
        logic               flag_next;

        // Operand selection for the fold this stage belongs to.
        if (F == 0)
        begin : g_fold_z
            assign k_in     = z_reg[g-1];
            assign p_in     = x_reg[g-1];
            assign q_in     = y_reg[g-1];
            assign len      = cell_c_z_reg;
            assign dp       = cell_c_x_reg;
            assign dq       = cell_c_y_reg;
            assign prev_k   = z_reg[g-1];
            assign prev_len = cell_c_z_reg;
        end
        else if (F == 1)
        begin : g_fold_y
            assign k_in     = y_reg[g-1];
            assign p_in     = x_reg[g-1];
            assign q_in     = 32'sd0;
            assign len      = cell_b_y_reg;
            assign dp       = cell_b_x_reg;
            assign dq       = 32'sd0;
            assign prev_k   = z_reg[g-1];
            assign prev_len = cell_c_z_reg;
        end
        else
        begin : g_fold_x
            assign k_in     = x_reg[g-1];
            assign p_in     = 32'sd0;
            assign q_in     = 32'sd0;
            assign len      = cell_a_x_reg;
            assign dp       = 32'sd0;
            assign dq       = 32'sd0;
            assign prev_k   = y_reg[g-1];
            assign prev_len = cell_b_y_reg;
        end

        always_comb
        begin
            // The component moves monotonically, so a fresh test per step matches the loop.
            move = SUB ? above_cell(k_in, len) : below_cell(k_in, len);
            k_s  = sat_add(k_in, addend({2'b00, len}, SUB));
            p_s  = sat_add(p_in, addend({dp[31], dp}, SUB));
            q_s  = sat_add(q_in, addend({dq[31], dq}, SUB));

            // The first step of a later fold checks that the previous fold reached range.
            prev_bad = (FIRST && (F > 0))
                     && (below_cell(prev_k, prev_len) || above_cell(prev_k, prev_len));

            flag_next = flag_reg[g-1] | prev_bad
                      | (move & (k_s.ovf | p_s.ovf | q_s.ovf));

            x_next = x_reg[g-1];
            y_next = y_reg[g-1];
            z_next = z_reg[g-1];
            if (move)
            begin
                if (F == 0)
                begin
                    z_next = k_s.val;
                    x_next = p_s.val;
                    y_next = q_s.val;
                end
                else if (F == 1)
                begin
                    y_next = k_s.val;
                    x_next = p_s.val;
                end
                else
                begin
                    x_next = k_s.val;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[g]    <= x_next;
            y_reg[g]    <= y_next;
            z_reg[g]    <= z_next;
            flag_reg[g] <= flag_next;
        end
    end

    // Output stage: range check of the x fold and the result strobe.
    always_comb
    begin
        nr_next = flag_reg[NUM_STEPS]
                | below_cell(x_reg[NUM_STEPS], cell_a_x_reg)
                | above_cell(x_reg[NUM_STEPS], cell_a_x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[NUM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= x_reg[NUM_STEPS];
        wy_reg <= y_reg[NUM_STEPS];
        wz_reg <= z_reg[NUM_STEPS];
        nr_reg <= nr_next;
    end

    assign done        = done_reg;
    assign wrapped_x   = wx_reg;
    assign wrapped_y   = wy_reg;
    assign wrapped_z   = wz_reg;
    assign not_reduced = nr_reg;

endmodule

`default_nettype wire
